>>> hdl/olv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered value list package
// Shared types for the ordered value list: operation and status codes, the
// input and result beats, the cell control word and the sequencer states.
// ----------------------------------------------------------------------------
package olv_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [6:0]         position;
        logic signed [31:0] entry_value;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_ROTATE,
        MOVE_COMPACT
    } t_move;

    typedef struct packed {
        t_move move;
        logic  cmp;
        logic  prop;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_CMP,
        S_DEL_PROP,
        S_DEL_SHIFT,
        S_READ
    } t_state;

endpackage
`default_nettype wire

>>> hdl/olv_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered value list cell
// Holds one list entry, compares it with the delete key, passes a match
// flag to its right neighbour and takes its right neighbour's value when
// the list rotates or closes a gap.
// ----------------------------------------------------------------------------
module olv_cell
    import olv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic               i_live,
    input  wire logic               i_load,
    input  wire logic signed [31:0] i_ins_value,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_right_value,
    input  wire logic               i_left_flag,
    output logic signed [31:0]      o_value,
    output logic                    o_flag
);

    logic signed [31:0] r_value;
    logic               r_match;
    logic               r_pre;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_ins_value;
        end else begin
            case (i_ctl.move)
                MOVE_ROTATE: begin
                    r_value <= i_right_value;
                end
                MOVE_COMPACT: begin
                    if (r_pre || r_match) begin
                        r_value <= i_right_value;
                    end
                end
                default: begin
                    r_value <= r_value;
                end
            endcase
        end
        if (i_ctl.cmp) begin
            r_match <= i_live && (r_value == i_key);
            r_pre   <= 1'b0;
        end else if (i_ctl.prop) begin
            r_pre <= i_left_flag;
        end
    end

    assign o_value = r_value;
    assign o_flag  = r_pre || r_match;

endmodule
`default_nettype wire

>>> hdl/ordered_value_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered value list
// Keeps an ordered list of signed values in a ring of cells. Insert appends
// at the tail, delete removes the first matching entry and closes the gap,
// read-out emits every entry in order, clear empties the list.
// ----------------------------------------------------------------------------
// Insert and clear complete when accepted; their result is registered at once.
// Delete steps through a compare state, a propagate state (skipped for a single
// cell) in which the match flag ripples along the cell chain, and a shift state
// that closes the gap. Read-out rotates the ring once, one result beat a cycle
// per live entry while the output is not stalled. Reset clears the entry count,
// sequencer and output valid; the stored values are left undefined.
// ----------------------------------------------------------------------------
module ordered_value_list
    import olv_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_item   i_in_item,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_out_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_step, n_step;
    logic signed [31:0] r_key, n_key;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    t_cell_ctl          cell_ctl;
    logic               ins_load;
    logic               out_free;
    logic               accept;
    logic [CNT_W-1:0]   step_inc;
    logic signed [31:0] cell_value [CAPACITY];
    logic               cell_flag  [CAPACITY];
    logic               left_flag  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left_flag[g] = 1'b0;
        end else begin : g_body
            assign left_flag[g] = cell_flag[g-1];
        end

        olv_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_live        (CNT_W'(g) < r_count),
            .i_load        (ins_load && (CNT_W'(g) == r_count)),
            .i_ins_value   (i_in_item.value),
            .i_key         (r_key),
            .i_right_value (cell_value[(g + 1) % CAPACITY]),
            .i_left_flag   (left_flag[g]),
            .o_value       (cell_value[g]),
            .o_flag        (cell_flag[g])
        );
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign step_inc   = r_step + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_key <= n_key;
        r_out <= n_out;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_key         = r_key;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        cell_ctl.move = MOVE_HOLD;
        cell_ctl.cmp  = 1'b0;
        cell_ctl.prop = 1'b0;
        ins_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.position    = '0;
                    n_out.entry_value = '0;
                    n_out.last        = 1'b1;
                    n_out.status      = ST_OK;
                    case (i_in_item.kind)
                        KIND_INSERT: begin
                            n_out_valid = 1'b1;
                            if (r_count < CNT_W'(CAPACITY)) begin
                                ins_load = 1'b1;
                                n_count  = r_count + 1'b1;
                            end else begin
                                n_out.status = ST_FULL;
                            end
                        end
                        KIND_DELETE: begin
                            n_key   = i_in_item.value;
                            n_state = S_DEL_CMP;
                        end
                        KIND_READ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_step  = '0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_count     = '0;
                        end
                    endcase
                end
            end
            S_DEL_CMP: begin
                cell_ctl.cmp = 1'b1;
                n_step       = '0;
                n_state      = (CAPACITY > 1) ? S_DEL_PROP : S_DEL_SHIFT;
            end
            S_DEL_PROP: begin
                cell_ctl.prop = 1'b1;
                n_step        = step_inc;
                if (r_step == CNT_W'(CAPACITY - 2)) begin
                    n_state = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.position    = '0;
                    n_out.entry_value = '0;
                    n_out.last        = 1'b1;
                    if (cell_flag[CAPACITY-1]) begin
                        cell_ctl.move = MOVE_COMPACT;
                        n_count       = r_count - 1'b1;
                        n_out.status  = ST_OK;
                    end else begin
                        n_out.status  = ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if ((r_step >= r_count) || out_free) begin
                    cell_ctl.move = MOVE_ROTATE;
                    n_step        = step_inc;
                    if (r_step < r_count) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = ST_OK;
                        n_out.position    = 7'(step_inc);
                        n_out.entry_value = cell_value[0];
                        n_out.last        = (step_inc == r_count);
                    end
                    if (r_step == CNT_W'(CAPACITY - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.kind == KIND_INSERT) && (r_count < CNT_W'(CAPACITY)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("Insert into a list with room did not grow it by one.");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_READ) && (n_out_valid && !(r_out_valid && i_out_stall)))
        |-> (n_out.last == (n_out.position == 7'(r_count))))
        else $error("Read-out beat marked last at the wrong position.");

endmodule
`default_nettype wire
